>>> rtl/boolean_network_step_assert.svh
// Assertion macros for the boolean network step engine and its checker.
// Each macro expects signals named clock and reset in the using scope.
`ifndef BOOLEAN_NETWORK_STEP_ASSERT_SVH
`define BOOLEAN_NETWORK_STEP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define BNS_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define BNS_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/bns_pkg.sv
// Shared constants and types for the boolean network step engine.
// No dependencies; imported by the top level and the checker.
package bns_pkg;

   localparam int NODES_DEFAULT = 64;
   localparam int MAX_K_DEFAULT = 4;

   localparam int OP_W         = 3;
   localparam int NODE_FIELD_W = 6;
   localparam int SLOT_W       = 2;
   localparam int SRC_W        = 6;
   localparam int TABLE_W      = 16;
   localparam int STATE_W      = 64;
   localparam int COUNT_W      = 7;
   localparam int DEGREE_W     = 3;

   typedef logic [OP_W-1:0] op_type;

   localparam op_type OP_WIRE  = 3'd0;
   localparam op_type OP_TRUTH = 3'd1;
   localparam op_type OP_LOAD  = 3'd2;
   localparam op_type OP_FLIP  = 3'd3;
   localparam op_type OP_STEP  = 3'd4;

   localparam logic [DEGREE_W-1:0] DEGREE_RESET = 3'd2;

endpackage

>>> rtl/boolean_network_step.sv
// Boolean network step engine: one request at a time, result in an output register.
// Step: the nodes are evaluated one per cycle through the shared evaluation unit, with the
// RAM read one node ahead of evaluation. Load: the change count is formed one bit per
// cycle. Wiring write: row read-modify-write. Other operations go straight to the result.
// A new request is taken the cycle after the result is registered.
// Synchronous reset clears the state to zero and in_degree to 2; tables are not cleared.
module boolean_network_step
   import bns_pkg::*;
#(
   parameter int NODES = NODES_DEFAULT,
   parameter int MAX_K = MAX_K_DEFAULT
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [OP_W-1:0]         req_operation,
   input  logic [NODE_FIELD_W-1:0] req_node,
   input  logic [SLOT_W-1:0]       req_slot,
   input  logic [SRC_W-1:0]        req_source,
   input  logic [TABLE_W-1:0]      req_table_word,
   input  logic [STATE_W-1:0]      req_state_word,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [STATE_W-1:0]      rsp_state_after,
   output logic [COUNT_W-1:0]      rsp_changed_count,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [DEGREE_W-1:0]     csr_in_degree
);

   localparam int NODE_W = $clog2(NODES);
   localparam int CNT_W  = $clog2(NODES + 1);
   localparam int ROW_W  = MAX_K * SRC_W;

   localparam logic [NODE_W-1:0] LAST_NODE = NODE_W'(NODES - 1);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_WIRE  = 3'd1;
   localparam logic [2:0] ST_EVAL  = 3'd2;
   localparam logic [2:0] ST_COUNT = 3'd3;
   localparam logic [2:0] ST_DONE  = 3'd4;

   logic [2:0]          state_ff, state_in;
   logic [NODES-1:0]    node_bits_ff, node_bits_in;
   logic [NODES-1:0]    nxt_ff, nxt_in;
   logic [NODES-1:0]    diff_ff, diff_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [NODE_W-1:0]   addr_ff, addr_in;
   logic                issue_ff, issue_in;
   logic                eval_v_ff, eval_v_in;
   logic [NODE_W-1:0]   eval_node_ff, eval_node_in;
   logic [NODE_W-1:0]   wr_node_ff, wr_node_in;
   logic [SLOT_W-1:0]   wr_slot_ff, wr_slot_in;
   logic [SRC_W-1:0]    wr_src_ff, wr_src_in;
   logic [DEGREE_W-1:0] in_degree_ff, in_degree_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATE_W-1:0]  rsp_state_ff, rsp_state_in;
   logic [COUNT_W-1:0]  rsp_count_ff, rsp_count_in;

   logic                req_accept;
   logic                node_ok;
   logic                slot_ok;
   logic [DEGREE_W-1:0] k_eff;
   logic [NODE_W-1:0]   rd_addr;
   logic [ROW_W-1:0]    wire_rd_data;
   logic [ROW_W-1:0]    wire_wr_data;
   logic                wire_wr_en;
   logic [TABLE_W-1:0]  tt_rd_data;
   logic                tt_wr_en;
   logic [MAX_K-1:0]    idx;
   logic [7:0]          idx_wide;
   logic                new_bit;
   logic                old_bit;

   bns_ram #(.WIDTH(ROW_W), .DEPTH(NODES)) u_wire_ram (
      .clock   (clock),
      .wr_en   (wire_wr_en),
      .wr_addr (wr_node_ff),
      .wr_data (wire_wr_data),
      .rd_addr (rd_addr),
      .rd_data (wire_rd_data)
   );

   bns_ram #(.WIDTH(TABLE_W), .DEPTH(NODES)) u_truth_ram (
      .clock   (clock),
      .wr_en   (tt_wr_en),
      .wr_addr (req_node[NODE_W-1:0]),
      .wr_data (req_table_word),
      .rd_addr (rd_addr),
      .rd_data (tt_rd_data)
   );

   assign req_ready  = (state_ff == ST_IDLE);
   assign req_accept = req_valid && req_ready;
   assign csr_ready  = 1'b1;
   assign node_ok    = {1'b0, req_node} < (NODE_FIELD_W + 1)'(NODES);
   assign slot_ok    = {1'b0, req_slot} < (SLOT_W + 1)'(MAX_K);
   assign k_eff      = (in_degree_ff > DEGREE_W'(MAX_K)) ? DEGREE_W'(MAX_K) : in_degree_ff;

   // Shared evaluation unit: one node's row and table per cycle.
   always_comb begin
      logic [SRC_W-1:0] src_sel;
      src_sel = '0;
      idx     = '0;
      for (int s = 0; s < MAX_K; s++) begin
         src_sel = wire_rd_data[s*SRC_W +: SRC_W];
         if ((DEGREE_W'(s) < k_eff) && ({1'b0, src_sel} < (SRC_W + 1)'(NODES))) begin
            idx[s] = node_bits_ff[src_sel[NODE_W-1:0]];
         end
      end
      idx_wide = {{(8 - MAX_K){1'b0}}, idx};
      new_bit  = (idx_wide < 8'(TABLE_W)) ? tt_rd_data[idx_wide[3:0]] : 1'b0;
      old_bit  = node_bits_ff[eval_node_ff];
   end

   // Replace one slot of the row read back for a wiring write.
   always_comb begin
      wire_wr_data = wire_rd_data;
      for (int s = 0; s < MAX_K; s++) begin
         if ((SLOT_W + 1)'(s) == {1'b0, wr_slot_ff}) begin
            wire_wr_data[s*SRC_W +: SRC_W] = wr_src_ff;
         end
      end
   end

   always_comb begin
      state_in     = state_ff;
      node_bits_in = node_bits_ff;
      nxt_in       = nxt_ff;
      diff_in      = diff_ff;
      cnt_in       = cnt_ff;
      addr_in      = addr_ff;
      issue_in     = issue_ff;
      eval_v_in    = eval_v_ff;
      eval_node_in = eval_node_ff;
      wr_node_in   = wr_node_ff;
      wr_slot_in   = wr_slot_ff;
      wr_src_in    = wr_src_ff;
      rsp_state_in = rsp_state_ff;
      rsp_count_in = rsp_count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      in_degree_in = csr_valid ? csr_in_degree : in_degree_ff;
      wire_wr_en   = 1'b0;
      tt_wr_en     = 1'b0;
      rd_addr      = addr_ff;

      unique case (state_ff)
         ST_IDLE: begin
            rd_addr = req_node[NODE_W-1:0];
            if (req_accept) begin
               cnt_in     = '0;
               wr_node_in = req_node[NODE_W-1:0];
               wr_slot_in = req_slot;
               wr_src_in  = req_source;
               state_in   = ST_DONE;
               unique case (req_operation)
                  OP_WIRE: begin
                     if (node_ok && slot_ok) begin
                        state_in = ST_WIRE;
                     end
                  end
                  OP_TRUTH: begin
                     tt_wr_en = node_ok;
                  end
                  OP_LOAD: begin
                     node_bits_in = req_state_word[NODES-1:0];
                     diff_in      = node_bits_ff ^ req_state_word[NODES-1:0];
                     addr_in      = '0;
                     state_in     = ST_COUNT;
                  end
                  OP_FLIP: begin
                     if (node_ok) begin
                        node_bits_in = node_bits_ff ^ (NODES'(1) << req_node[NODE_W-1:0]);
                        cnt_in       = CNT_W'(1);
                     end
                  end
                  OP_STEP: begin
                     addr_in   = '0;
                     issue_in  = 1'b1;
                     eval_v_in = 1'b0;
                     state_in  = ST_EVAL;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_WIRE: begin
            wire_wr_en = 1'b1;
            state_in   = ST_DONE;
         end
         ST_EVAL: begin
            // issue reads one node ahead of evaluation
            eval_v_in    = issue_ff;
            eval_node_in = addr_ff;
            if (issue_ff) begin
               if (addr_ff == LAST_NODE) begin
                  issue_in = 1'b0;
               end else begin
                  addr_in = addr_ff + NODE_W'(1);
               end
            end
            if (eval_v_ff) begin
               nxt_in = {new_bit, nxt_ff[NODES-1:1]};
               cnt_in = cnt_ff + CNT_W'(new_bit ^ old_bit);
               if (eval_node_ff == LAST_NODE) begin
                  node_bits_in = {new_bit, nxt_ff[NODES-1:1]};
                  state_in     = ST_DONE;
               end
            end
         end
         ST_COUNT: begin
            diff_in = diff_ff >> 1;
            cnt_in  = cnt_ff + CNT_W'(diff_ff[0]);
            if (addr_ff == LAST_NODE) begin
               state_in = ST_DONE;
            end else begin
               addr_in = addr_ff + NODE_W'(1);
            end
         end
         ST_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_state_in = STATE_W'(node_bits_ff);
               rsp_count_in = COUNT_W'(cnt_ff);
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         node_bits_ff <= '0;
         issue_ff     <= 1'b0;
         eval_v_ff    <= 1'b0;
         in_degree_ff <= DEGREE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         node_bits_ff <= node_bits_in;
         issue_ff     <= issue_in;
         eval_v_ff    <= eval_v_in;
         in_degree_ff <= in_degree_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      nxt_ff       <= nxt_in;
      diff_ff      <= diff_in;
      cnt_ff       <= cnt_in;
      addr_ff      <= addr_in;
      eval_node_ff <= eval_node_in;
      wr_node_ff   <= wr_node_in;
      wr_slot_ff   <= wr_slot_in;
      wr_src_ff    <= wr_src_in;
      rsp_state_ff <= rsp_state_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_state_after   = rsp_state_ff;
   assign rsp_changed_count = rsp_count_ff;

endmodule

>>> rtl/bns_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; used for the wiring rows and the truth tables.
module bns_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/bns_checker.sv
// Port-level checker for the boolean network step engine, bound to the top level.
// Depends on bns_pkg and boolean_network_step_assert.svh.
`include "boolean_network_step_assert.svh"

module bns_checker
   import bns_pkg::*;
#(
   parameter int NODES = NODES_DEFAULT
) (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [STATE_W-1:0] rsp_state_after,
   input logic [COUNT_W-1:0] rsp_changed_count
);

   `BNS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid, "result dropped while stalled")
   `BNS_ASSERT_NEXT(a_rsp_stable, rsp_valid && !rsp_ready, $stable(rsp_state_after) && $stable(rsp_changed_count), "result changed while stalled")
   `BNS_ASSERT_NEXT(a_one_at_a_time, req_valid && req_ready, !req_ready, "request taken while busy")
   `BNS_ASSERT_SAME(a_count_range, rsp_valid, rsp_changed_count <= COUNT_W'(NODES), "change count above node count")

endmodule

bind boolean_network_step bns_checker #(.NODES(NODES)) u_bns_checker (.*);
